/* hdl/hwd_pkg.sv */
// Package for the hashed word dictionary: beat types, status codes,
// controller states and default sizes. No dependencies.
package hwd_pkg;

  localparam int NUM_BUCKETS_DEF  = 1024;
  localparam int MAX_WORD_LEN_DEF = 45;
  localparam int POOL_ENTRIES_DEF = 4096;

  // running byte sum width, never overflows for words up to 63 bytes
  localparam int SUM_W   = 14;
  localparam int COUNT_W = 13;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] word_total;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HREAD,
    S_INS,
    S_LINK,
    S_WALK,
    S_META,
    S_CRD,
    S_CCMP,
    S_RES
  } state_t;

endpackage

/* hdl/hashed_word_dictionary.sv */
// Hashed word dictionary, chained hash table in on-chip memories.
// Depends on hwd_pkg.
//
// A word arrives one byte per beat on the char channel, one byte per cycle while the
// block waits for bytes. After the last byte the byte sum is reduced modulo NUM_BUCKETS
// by a reciprocal multiply, then a subtract. An overlong word or a refused insert then
// goes straight to its result, an insert reads its bucket head and links the new entry,
// and a check walks its bucket chain, comparing byte by byte each entry of equal length.
// Each memory (bucket heads, entry metadata, entry bytes, word buffer) has one write
// port and a registered read. The result beat is held in an output register; the next
// word's bytes are taken while it waits, and a word's result stalls only while the
// previous one has not been taken. After reset the bucket heads are cleared in turn,
// and no byte is accepted until all are clear.
module hashed_word_dictionary #(
  parameter int NUM_BUCKETS  = hwd_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_WORD_LEN = hwd_pkg::MAX_WORD_LEN_DEF,
  parameter int POOL_ENTRIES = hwd_pkg::POOL_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  hwd_pkg::char_beat_t char_beat,
  output logic                result_valid,
  input  logic                result_ready,
  output hwd_pkg::result_t    result
);

  localparam int SW    = hwd_pkg::SUM_W;
  localparam int CW    = hwd_pkg::COUNT_W;
  localparam int BKW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
  localparam int E_W   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int DW    = SW + 17;
  localparam int CHARS_DEPTH = POOL_ENTRIES * (2 ** IDX_W);
  // exact quotient for any SW-bit sum: floor(sum * RECIP / 2**RECIP_SH)
  localparam int RECIP_SH = SW + BKW;
  localparam int RECIP_W  = SW + 2;
  localparam int PROD_W   = RECIP_SH + SW;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  hwd_pkg::state_t state, state_next;

  logic [LEN_W-1:0] wlen;
  logic [SW-1:0]    sum;
  logic             too_long;
  logic             op;
  logic [3:0]       mod_k;
  logic [SW-1:0]    quot;
  logic [BKW-1:0]   clr_cnt;
  logic [PTR_W-1:0] used;
  logic [PTR_W-1:0] link;
  logic [PTR_W-1:0] next_link;
  logic [E_W-1:0]   cur_e;
  logic [IDX_W-1:0] idx;
  logic             res_found;
  logic [1:0]       res_status;

  logic [7:0]       wbuf [MAX_WORD_LEN];
  logic [7:0]       chars [CHARS_DEPTH];
  logic [LEN_W+PTR_W-1:0] meta [POOL_ENTRIES];
  logic [PTR_W-1:0] head [NUM_BUCKETS];

  logic [7:0]       wbuf_q;
  logic [7:0]       chars_q;
  logic [LEN_W+PTR_W-1:0] meta_q;
  logic [PTR_W-1:0] head_q;

  logic             accept;
  logic [7:0]       folded;
  logic             room;
  logic             pool_full;
  logic [PROD_W-1:0] recip_prod;
  logic [SW+BKW-1:0] sum_ext;
  logic [BKW-1:0]   bucket;
  logic [PTR_W-1:0] link_m1;
  logic [LEN_W-1:0] meta_len;
  logic [PTR_W-1:0] meta_next;
  logic             last_idx;
  logic             out_free;
  logic [PTR_W+CW-1:0] used_ext;

  assign accept     = char_valid & char_ready;
  assign folded     = (char_beat.char_code inside {[8'h41:8'h5a]})
                      ? char_beat.char_code + 8'd32 : char_beat.char_code;
  assign room       = wlen < LEN_W'(MAX_WORD_LEN);
  assign pool_full  = used == PTR_W'(POOL_ENTRIES);
  assign recip_prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign sum_ext    = {{BKW{1'b0}}, sum};
  assign bucket     = sum_ext[BKW-1:0];
  assign link_m1    = link - PTR_W'(1);
  assign meta_len   = meta_q[LEN_W+PTR_W-1:PTR_W];
  assign meta_next  = meta_q[PTR_W-1:0];
  assign last_idx   = (LEN_W'(idx) + LEN_W'(1)) == wlen;
  assign out_free   = !result_valid || result_ready;
  assign used_ext   = {{CW{1'b0}}, used};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hwd_pkg::S_CLEAR: if (clr_cnt == BKW'(NUM_BUCKETS - 1)) state_next = hwd_pkg::S_IDLE;
      hwd_pkg::S_IDLE: if (accept && char_beat.last_char) state_next = hwd_pkg::S_MOD;
      hwd_pkg::S_MOD: begin
        if (mod_k == 4'd0) begin
          if (too_long || (op == hwd_pkg::OP_INSERT && pool_full)) begin
            state_next = hwd_pkg::S_RES;
          end else begin
            state_next = hwd_pkg::S_HREAD;
          end
        end
      end
      hwd_pkg::S_HREAD: state_next = (op == hwd_pkg::OP_INSERT) ? hwd_pkg::S_INS
                                                                 : hwd_pkg::S_LINK;
      hwd_pkg::S_INS:  state_next = hwd_pkg::S_RES;
      hwd_pkg::S_LINK: state_next = hwd_pkg::S_WALK;
      hwd_pkg::S_WALK: state_next = (link == '0) ? hwd_pkg::S_RES : hwd_pkg::S_META;
      hwd_pkg::S_META: state_next = (meta_len == wlen) ? hwd_pkg::S_CRD : hwd_pkg::S_WALK;
      hwd_pkg::S_CRD:  state_next = hwd_pkg::S_CCMP;
      hwd_pkg::S_CCMP: begin
        if (chars_q != wbuf_q) begin
          state_next = hwd_pkg::S_WALK;
        end else if (last_idx) begin
          state_next = hwd_pkg::S_RES;
        end else begin
          state_next = hwd_pkg::S_CRD;
        end
      end
      hwd_pkg::S_RES: if (out_free) state_next = hwd_pkg::S_IDLE;
      default: state_next = hwd_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    char_ready = (state == hwd_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // word collection, reduction, insert count, chain walk and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      wlen         <= '0;
      sum          <= '0;
      too_long     <= 1'b0;
      used         <= '0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != hwd_pkg::S_RES) result_valid <= 1'b0;
      case (state)
        hwd_pkg::S_CLEAR: clr_cnt <= clr_cnt + BKW'(1);
        hwd_pkg::S_IDLE: begin
          if (accept) begin
            if (room) begin
              wlen <= wlen + LEN_W'(1);
              sum  <= sum + SW'(folded);
            end else begin
              too_long <= 1'b1;
            end
            op         <= char_beat.operation;
            mod_k      <= 4'd1;
            res_found  <= 1'b0;
            res_status <= hwd_pkg::ST_OK;
          end
        end
        hwd_pkg::S_MOD: begin
          // with mod_k at one it takes the quotient, at zero it leaves the remainder in sum
          if (mod_k == 4'd1) begin
            quot <= recip_prod[PROD_W-1:RECIP_SH];
          end else begin
            sum <= sum - quot * SW'(NUM_BUCKETS);
          end
          mod_k <= mod_k - 4'd1;
          if (mod_k == 4'd0) begin
            if (too_long) begin
              res_status <= hwd_pkg::ST_LONG;
            end else if (op == hwd_pkg::OP_INSERT && pool_full) begin
              res_status <= hwd_pkg::ST_FULL;
            end
          end
        end
        hwd_pkg::S_INS:  used <= used + PTR_W'(1);
        hwd_pkg::S_LINK: link <= head_q;
        hwd_pkg::S_WALK: cur_e <= link_m1[E_W-1:0];
        hwd_pkg::S_META: begin
          idx       <= '0;
          next_link <= meta_next;
          if (meta_len != wlen) link <= meta_next;
        end
        hwd_pkg::S_CCMP: begin
          if (chars_q != wbuf_q) begin
            link <= next_link;
          end else if (last_idx) begin
            res_found <= 1'b1;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        hwd_pkg::S_RES: begin
          if (out_free) begin
            result_valid      <= 1'b1;
            result.found      <= res_found;
            result.status     <= res_status;
            result.word_total <= used_ext[CW-1:0];
            wlen              <= '0;
            sum               <= '0;
            too_long          <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // word buffer
  always_ff @(posedge clk) begin
    if (accept && room) wbuf[wlen[IDX_W-1:0]] <= folded;
    wbuf_q <= wbuf[idx];
  end

  // entry bytes, written ahead into the next free slot while the word arrives
  always_ff @(posedge clk) begin
    if (accept && room && !pool_full) chars[{used[E_W-1:0], wlen[IDX_W-1:0]}] <= folded;
    chars_q <= chars[{cur_e, idx}];
  end

  // entry length and chain link
  always_ff @(posedge clk) begin
    if (state == hwd_pkg::S_INS) meta[used[E_W-1:0]] <= {wlen, head_q};
    meta_q <= meta[link_m1[E_W-1:0]];
  end

  // bucket heads, zero means empty chain
  always_ff @(posedge clk) begin
    if (state == hwd_pkg::S_CLEAR) begin
      head[clr_cnt] <= '0;
    end else if (state == hwd_pkg::S_INS) begin
      head[bucket] <= used + PTR_W'(1);
    end
    head_q <= head[bucket];
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= PTR_W'(POOL_ENTRIES))
    else $error("pool count beyond pool size");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    wlen <= LEN_W'(MAX_WORD_LEN))
    else $error("word length beyond maximum");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    state == hwd_pkg::S_INS |-> !pool_full && !too_long)
    else $error("insert into full pool or of overlong word");

  a_bucket_reduced: assert property (@(posedge clk) disable iff (rst)
    state == hwd_pkg::S_HREAD |-> {17'b0, sum} < DW'(NUM_BUCKETS))
    else $error("bucket not reduced before head read");

endmodule
